// ===== rtl/trh_pkg.sv =====
// Shared types and constants for the timestamped ring history block.
package trh_pkg;

    localparam int STAMP_W   = 48;
    localparam int PAYLOAD_W = 32;
    localparam int WANT_W    = 16;
    localparam int WINDOW_W  = 32;
    localparam int HELD_W    = 7;
    // Signed compare width: stamp plus sign and borrow room
    localparam int CMP_W     = STAMP_W + 2;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_LAST   = 2'd1,
        OP_WINDOW = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [STAMP_W-1:0]   stamp;
        logic [PAYLOAD_W-1:0] payload;
        logic [WANT_W-1:0]    want_count;
        logic [WINDOW_W-1:0]  window_ms;
    } in_item_t;

    typedef struct packed {
        logic                 item_valid;
        logic [STAMP_W-1:0]   out_stamp;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 last_of_run;
        logic [HELD_W-1:0]    held_count;
        logic                 is_full;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_SCAN,
        S_PREP,
        S_EMIT,
        S_EMPTY
    } state_t;

    typedef enum logic [1:0] {
        RD_NEWEST,
        RD_WALK,
        RD_EMIT
    } rd_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    push;
        logic    latch_count;
        logic    latch_zero;
        logic    walk_start;
        logic    walk_head;
        logic    walk_step;
        logic    emit_start;
        logic    emit_issue;
        logic    emit_empty;
        logic    mem_rd;
        rd_sel_t rd_sel;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_zero;
        logic fill_one;
        logic n_zero;
        logic n_next_full;
        logic stamp_ok;
        logic left_zero;
        logic pend;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/trh_dpath.sv =====
// Datapath: record memory, ring pointers, walk and emit counters, output register.
module trh_dpath #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  trh_pkg::in_item_t   in_item,
    input  trh_pkg::cmd_t       cmd,
    output trh_pkg::stat_t      st,
    input  logic                out_ready,
    output logic                out_valid,
    output trh_pkg::out_item_t  out_item
);
    import trh_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int KEEP_W = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;

    // Record memory
    logic [STAMP_W-1:0] stamp_mem [CAPACITY];
    logic [KEEP_W-1:0]  pay_mem   [CAPACITY];
    logic [STAMP_W-1:0] stamp_q;
    logic [KEEP_W-1:0]  pay_q;
    logic [IDX_W-1:0]   rd_addr;

    // Control registers
    logic [IDX_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    left_reg, left_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    walk_reg, walk_next;
    logic                pend_reg, pend_next;
    logic                pend_last_reg, pend_last_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers
    logic [WINDOW_W-1:0]     window_reg;
    logic signed [CMP_W-1:0] cutoff_reg;
    out_item_t               out_item_reg, out_item_next;

    logic [CNT_W-1:0]        clamp;
    logic [CNT_W-1:0]        n_inc;
    logic signed [CMP_W-1:0] stamp_s;
    logic [HELD_W-1:0]       held;
    logic                    full;

    assign stamp_s = $signed({2'b00, stamp_q});
    assign n_inc   = n_reg + CNT_W'(1);
    assign held    = HELD_W'(fill_reg);
    assign full    = (fill_reg == CNT_W'(CAPACITY));

    // Clamp the requested count to the number held
    always_comb
    begin
        if (in_item.want_count > WANT_W'(fill_reg))
            clamp = fill_reg;
        else
            clamp = CNT_W'(in_item.want_count);
    end

    // Select the read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_NEWEST: rd_addr = wp_reg - IDX_W'(1);
            RD_WALK:   rd_addr = walk_reg;
            RD_EMIT:   rd_addr = idx_reg;
            default:   rd_addr = idx_reg;
        endcase
    end

    // Write on push, read with a registered port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stamp_mem[wp_reg] <= in_item.stamp;
            pay_mem[wp_reg]   <= in_item.payload[KEEP_W-1:0];
        end
        if (cmd.mem_rd)
        begin
            stamp_q <= stamp_mem[rd_addr];
            pay_q   <= pay_mem[rd_addr];
        end
    end

    // Next-state logic for pointers, counters and output
    always_comb
    begin
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        n_next         = n_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;
        walk_next      = walk_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (cmd.push)
        begin
            wp_next = wp_reg + IDX_W'(1);
            if (fill_reg != CNT_W'(CAPACITY))
                fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.latch_count)
            n_next = clamp;
        if (cmd.latch_zero)
            n_next = '0;
        if (cmd.walk_start)
            walk_next = wp_reg - IDX_W'(2);
        if (cmd.walk_head)
        begin
            n_next    = CNT_W'(1);
            walk_next = walk_reg - IDX_W'(1);
        end
        if (cmd.walk_step)
        begin
            n_next    = n_inc;
            walk_next = walk_reg - IDX_W'(1);
        end
        if (cmd.emit_start)
        begin
            idx_next  = wp_reg - n_reg[IDX_W-1:0];
            left_next = n_reg;
        end
        if (cmd.emit_issue)
        begin
            idx_next       = idx_reg + IDX_W'(1);
            left_next      = left_reg - CNT_W'(1);
            pend_next      = 1'b1;
            pend_last_next = (left_reg == CNT_W'(1));
        end

        // Drop a taken result, then load a fresh one
        if (out_ready)
            out_valid_next = 1'b0;
        if (pend_reg)
        begin
            out_valid_next            = 1'b1;
            out_item_next.item_valid  = 1'b1;
            out_item_next.out_stamp   = stamp_q;
            out_item_next.out_payload = PAYLOAD_W'(pay_q);
            out_item_next.last_of_run = pend_last_reg;
            out_item_next.held_count  = held;
            out_item_next.is_full     = full;
        end
        if (cmd.emit_empty)
        begin
            out_valid_next            = 1'b1;
            out_item_next.item_valid  = 1'b0;
            out_item_next.out_stamp   = '0;
            out_item_next.out_payload = '0;
            out_item_next.last_of_run = 1'b1;
            out_item_next.held_count  = held;
            out_item_next.is_full     = full;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            n_reg         <= '0;
            left_reg      <= '0;
            idx_reg       <= '0;
            walk_reg      <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            n_reg         <= n_next;
            left_reg      <= left_next;
            idx_reg       <= idx_next;
            walk_reg      <= walk_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (cmd.walk_start)
            window_reg <= in_item.window_ms;
        if (cmd.walk_head)
            cutoff_reg <= stamp_s - $signed({{(CMP_W-WINDOW_W){1'b0}}, window_reg});
    end

    // Status back to the controller
    always_comb
    begin
        st.fill_zero   = (fill_reg == '0);
        st.fill_one    = (fill_reg == CNT_W'(1));
        st.n_zero      = (n_reg == '0);
        st.n_next_full = (n_inc == fill_reg);
        st.stamp_ok    = (stamp_s >= cutoff_reg);
        st.left_zero   = (left_reg == '0);
        st.pend        = pend_reg;
        st.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A memory result never lands on a waiting output
    a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg)
        else $error("memory result loaded over a waiting output");

    // Issue only with records left and no read in flight
    a_issue_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_issue |-> (left_reg != '0) && !pend_reg && (!out_valid_reg || out_ready))
        else $error("emit read issued out of turn");

    // The walk never counts past the records held
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (n_reg < fill_reg))
        else $error("window walk passed the fill count");

    // Fill count stays within capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

endmodule

// ===== rtl/trh_ctrl.sv =====
// Controller: sequences push, window walk and result emission.
module trh_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  trh_pkg::stat_t     st,
    output trh_pkg::cmd_t      cmd
);
    import trh_pkg::*;

    state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Decide next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.rd_sel = RD_EMIT;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (operation)
                        OP_PUSH:
                            cmd.push = 1'b1;
                        OP_LAST:
                        begin
                            cmd.latch_count = 1'b1;
                            state_next      = S_PREP;
                        end
                        OP_WINDOW:
                        begin
                            if (st.fill_zero)
                            begin
                                cmd.latch_zero = 1'b1;
                                state_next     = S_PREP;
                            end
                            else
                            begin
                                cmd.walk_start = 1'b1;
                                cmd.mem_rd     = 1'b1;
                                cmd.rd_sel     = RD_NEWEST;
                                state_next     = S_HEAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Newest record is in; fix the cutoff and read the next older one
            S_HEAD:
            begin
                cmd.walk_head = 1'b1;
                cmd.mem_rd    = 1'b1;
                cmd.rd_sel    = RD_WALK;
                state_next    = st.fill_one ? S_PREP : S_SCAN;
            end

            // Advance while the record lies inside the window and unread records remain
            S_SCAN:
            begin
                if (!st.stamp_ok)
                    state_next = S_PREP;
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.mem_rd    = 1'b1;
                    cmd.rd_sel    = RD_WALK;
                    if (st.n_next_full)
                        state_next = S_PREP;
                end
            end

            S_PREP:
            begin
                if (st.n_zero)
                    state_next = S_EMPTY;
                else
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (st.left_zero && !st.pend)
                    state_next = S_IDLE;
                else if (!st.left_zero && !st.pend && st.out_free)
                begin
                    cmd.emit_issue = 1'b1;
                    cmd.mem_rd     = 1'b1;
                    cmd.rd_sel     = RD_EMIT;
                end
            end

            S_EMPTY:
            begin
                if (st.out_free && !st.pend)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/timestamped_ring_history.sv =====
// Top level of the timestamped ring history: controller plus datapath.
//
// A ring of CAPACITY timestamped records that overwrites the oldest when full.
// Input channel (in_valid/in_ready/in_item) takes one operation per transfer:
// push, read the newest want_count records, or read the records whose stamp
// lies within window_ms of the newest. Output channel (out_valid/out_ready/
// out_item) returns read results oldest first; the final one carries
// last_of_run. An empty read returns one result with item_valid low.
// A push can be transferred every cycle while no read is in progress.
// A read holds the input channel until its last result is in the output
// register. A count read goes straight to emission; a window read first walks
// back from the newest over the records inside the window, stopping at an older
// one or when all held records are counted, then emits. Each result is read only
// after the previous one is loaded, as the record memory has one registered port.
// Reset clears the ring pointers and fill count; the record memory is not
// cleared, as only written entries are ever read. When the receiver stalls,
// the result waits in the output register and the read pauses; pushes are
// still taken once the read has handed over its last result.
module timestamped_ring_history #(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  trh_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output trh_pkg::out_item_t  out_item
);
    import trh_pkg::*;

    cmd_t  cmd;
    stat_t st;

    trh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (in_item.operation),
        .st        (st),
        .cmd       (cmd)
    );

    trh_dpath #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .st        (st),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
